>>> rtl/lsbe_pkg.sv
// Shared types, codes and constants of the LRU size-budget table.
`timescale 1ns / 1ps
package lsbe_pkg;

    localparam int STAMP_W        = 48;
    localparam int TOTAL_OUT_W    = 36;
    localparam int EVICT_OUT_W    = 6;
    localparam int IDX_W          = 5;
    localparam int SIZE_IN_W      = 31;
    localparam int BUDGET_W       = 16;
    localparam int INTERVAL_W     = 8;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int MIB_SHIFT      = 20;
    localparam int DEF_ENTRIES    = 32;
    localparam int DEF_SIZE_BITS  = 31;

    localparam logic [BUDGET_W-1:0]   RESET_BUDGET   = 16'd512;
    localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 8'd20;

    localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 8'd1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_TOUCH   = 2'd1,
        OP_QUERY   = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_STAMP = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               kind;
        logic [STAMP_W-1:0] stamp;
    } t_cell_cmd;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_EVICT = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

endpackage

>>> rtl/lsbe_cell.sv
// One table entry with its stage of the least-recently-used search chain.
`timescale 1ns / 1ps
module lsbe_cell #(
    parameter int SIZE_BITS = lsbe_pkg::DEF_SIZE_BITS,
    parameter int IW        = 5,
    parameter int INDEX     = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsbe_pkg::t_cell_cmd         i_cmd,
    input  logic                        i_sel,
    input  logic [SIZE_BITS-1:0]        i_size,
    input  logic                        i_found,
    input  logic [lsbe_pkg::STAMP_W-1:0] i_best_stamp,
    input  logic [IW-1:0]               i_best_idx,
    input  logic [SIZE_BITS-1:0]        i_best_bytes,
    output logic                        o_found,
    output logic [lsbe_pkg::STAMP_W-1:0] o_best_stamp,
    output logic [IW-1:0]               o_best_idx,
    output logic [SIZE_BITS-1:0]        o_best_bytes,
    output logic                        o_valid,
    output logic [SIZE_BITS-1:0]        o_bytes,
    output logic [lsbe_pkg::STAMP_W-1:0] o_stamp
);

    logic                         r_valid;
    logic [SIZE_BITS-1:0]         r_bytes;
    logic [lsbe_pkg::STAMP_W-1:0] r_stamp;
    logic                         w_take;

    // This entry replaces the running best only when strictly older, so ties go low.
    assign w_take = r_valid && (!i_found || (r_stamp < i_best_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_bytes <= '0;
            r_stamp <= '0;
        end else if (i_sel) begin
            case (i_cmd.kind)
                lsbe_pkg::CMD_WRITE: begin
                    r_valid <= 1'b1;
                    r_bytes <= i_size;
                    r_stamp <= i_cmd.stamp;
                end
                lsbe_pkg::CMD_STAMP: begin
                    r_stamp <= i_cmd.stamp;
                end
                lsbe_pkg::CMD_CLEAR: begin
                    r_valid <= 1'b0;
                    r_bytes <= '0;
                    r_stamp <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_found <= 1'b0;
        end else begin
            o_found <= i_found || r_valid;
        end
        if (w_take) begin
            o_best_stamp <= r_stamp;
            o_best_idx   <= IW'(INDEX);
            o_best_bytes <= r_bytes;
        end else begin
            o_best_stamp <= i_best_stamp;
            o_best_idx   <= i_best_idx;
            o_best_bytes <= i_best_bytes;
        end
    end

    assign o_valid = r_valid;
    assign o_bytes = r_bytes;
    assign o_stamp = r_stamp;

endmodule

>>> rtl/lru_size_budget_eviction_top.sv
// Top level of the LRU table with a size budget and periodic eviction.
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_ready    i_operation, i_entry_index, i_entry_size
// out       source     o_out_valid / i_out_ready  o_is_valid, o_total_in_use,
//                                                 o_evicted_count, o_use_stamp
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item's result reaches the output register through the APPLY and OUT states, with a
// CHECK state first when an allocation runs the budget check. Each entry evicted by a pass
// adds the check, a wave that crosses the row of cells one cell per cycle, and the clear.
// One item is in work at a time; the next one can be accepted as soon as the current result
// sits in the output register, and a result that is not taken holds the block.
// Reset is synchronous and active low and clears the whole table at once.
module lru_size_budget_eviction_top #(
    parameter int ENTRIES   = lsbe_pkg::DEF_ENTRIES,
    parameter int SIZE_BITS = lsbe_pkg::DEF_SIZE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic [lsbe_pkg::IDX_W-1:0]        i_entry_index,
    input  logic [lsbe_pkg::SIZE_IN_W-1:0]    i_entry_size,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_is_valid,
    output logic [lsbe_pkg::TOTAL_OUT_W-1:0]  o_total_in_use,
    output logic [lsbe_pkg::EVICT_OUT_W-1:0]  o_evicted_count,
    output logic [lsbe_pkg::STAMP_W-1:0]      o_use_stamp,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lsbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsbe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IW  = $clog2(ENTRIES);
    // The exact total can never exceed ENTRIES full-size entries.
    localparam int TW  = SIZE_BITS + IW + 1;
    localparam int LW  = lsbe_pkg::BUDGET_W + lsbe_pkg::MIB_SHIFT;
    localparam int CW  = (TW > LW) ? TW : LW;
    localparam int SCW = $clog2(ENTRIES + 1);

    localparam int STW = lsbe_pkg::STAMP_W;

    // Configuration registers.
    logic [lsbe_pkg::BUDGET_W-1:0]   r_budget;
    logic [lsbe_pkg::INTERVAL_W-1:0] r_interval;

    // Control and the item in work.
    lsbe_pkg::t_state              r_state;
    lsbe_pkg::t_op                 r_op;
    logic [lsbe_pkg::IDX_W-1:0]    r_idx;
    logic [SIZE_BITS-1:0]          r_size;
    logic                          r_in_range;
    logic [lsbe_pkg::INTERVAL_W-1:0] r_alloc;
    logic [TW-1:0]                 r_total;
    logic [STW-1:0]                r_stamp_ctr;
    logic [SCW-1:0]                r_scan;
    logic [SCW-1:0]                r_evict;

    // Output register.
    logic                          r_out_valid;
    logic                          r_out_is_valid;
    logic [lsbe_pkg::TOTAL_OUT_W-1:0] r_out_total;
    logic [lsbe_pkg::EVICT_OUT_W-1:0] r_out_evict;
    logic [STW-1:0]                r_out_stamp;

    logic [lsbe_pkg::INTERVAL_W-1:0] w_alloc_next;
    logic [lsbe_pkg::INTERVAL_W-1:0] w_interval;
    logic                          w_in_range;
    logic                          w_accept;
    logic                          w_over;
    logic [STW-1:0]                n_stamp_ctr;

    // Row of cells and its search chain.
    lsbe_pkg::t_cell_cmd           w_cmd;
    logic [ENTRIES-1:0]            w_sel;
    logic [ENTRIES-1:0]            c_found;
    logic [STW-1:0]                c_stamp [ENTRIES];
    logic [IW-1:0]                 c_idx   [ENTRIES];
    logic [SIZE_BITS-1:0]          c_bytes [ENTRIES];
    logic [ENTRIES-1:0]            c_valid;
    logic [SIZE_BITS-1:0]          c_own_bytes [ENTRIES];
    logic [STW-1:0]                c_own_stamp [ENTRIES];

    // Read port at the named entry.
    logic                          w_rd_valid;
    logic [SIZE_BITS-1:0]          w_rd_bytes;
    logic [STW-1:0]                w_rd_stamp;
    logic [TW-1:0]                 w_rd_charge;

    logic                          w_best_found;
    logic [IW-1:0]                 w_best_idx;
    logic [SIZE_BITS-1:0]          w_best_bytes;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == lsbe_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_in_range  = (32'(i_entry_index) < ENTRIES);
    assign w_alloc_next = r_alloc + 1'b1;
    // An interval of zero behaves as one.
    assign w_interval  = (r_interval == '0) ? lsbe_pkg::INTERVAL_W'(1) : r_interval;
    assign w_over      = (CW'(r_total) > CW'({r_budget, {lsbe_pkg::MIB_SHIFT{1'b0}}}));
    assign n_stamp_ctr = r_stamp_ctr + 1'b1;

    assign w_best_found = c_found[ENTRIES-1];
    assign w_best_idx   = c_idx[ENTRIES-1];
    assign w_best_bytes = c_bytes[ENTRIES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget   <= lsbe_pkg::RESET_BUDGET;
            r_interval <= lsbe_pkg::RESET_INTERVAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == lsbe_pkg::REG_BUDGET) begin
                r_budget <= i_cfg_data;
            end else if (i_cfg_index == lsbe_pkg::REG_INTERVAL) begin
                r_interval <= i_cfg_data[lsbe_pkg::INTERVAL_W-1:0];
            end
        end
    end

    // The named entry is read through a select over the row.
    always_comb begin
        w_rd_valid = 1'b0;
        w_rd_bytes = '0;
        w_rd_stamp = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (32'(r_idx) == i) begin
                w_rd_valid = c_valid[i];
                w_rd_bytes = c_own_bytes[i];
                w_rd_stamp = c_own_stamp[i];
            end
        end
    end

    assign w_rd_charge = w_rd_valid ? TW'(w_rd_bytes) : '0;

    // Command and select lines for the row.
    always_comb begin
        w_cmd.kind  = lsbe_pkg::CMD_NONE;
        w_cmd.stamp = n_stamp_ctr;
        w_sel       = '0;
        if (r_state == lsbe_pkg::ST_EVICT) begin
            w_cmd.kind = lsbe_pkg::CMD_CLEAR;
            for (int i = 0; i < ENTRIES; i++) begin
                w_sel[i] = w_best_found && (32'(w_best_idx) == i);
            end
        end else if (r_state == lsbe_pkg::ST_APPLY) begin
            for (int i = 0; i < ENTRIES; i++) begin
                w_sel[i] = (32'(r_idx) == i);
            end
            case (r_op)
                lsbe_pkg::OP_ALLOC:   w_cmd.kind = lsbe_pkg::CMD_WRITE;
                lsbe_pkg::OP_TOUCH:   w_cmd.kind = w_rd_valid ? lsbe_pkg::CMD_STAMP
                                                              : lsbe_pkg::CMD_NONE;
                lsbe_pkg::OP_QUERY:   w_cmd.kind = lsbe_pkg::CMD_STAMP;
                lsbe_pkg::OP_RELEASE: w_cmd.kind = lsbe_pkg::CMD_CLEAR;
                default:              w_cmd.kind = lsbe_pkg::CMD_NONE;
            endcase
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic                 w_prev_found;
        logic [STW-1:0]       w_prev_stamp;
        logic [IW-1:0]        w_prev_idx;
        logic [SIZE_BITS-1:0] w_prev_bytes;

        // The search wave enters the first cell empty.
        if (g == 0) begin : g_head
            assign w_prev_found = 1'b0;
            assign w_prev_stamp = '0;
            assign w_prev_idx   = '0;
            assign w_prev_bytes = '0;
        end else begin : g_link
            assign w_prev_found = c_found[g-1];
            assign w_prev_stamp = c_stamp[g-1];
            assign w_prev_idx   = c_idx[g-1];
            assign w_prev_bytes = c_bytes[g-1];
        end

        lsbe_cell #(
            .SIZE_BITS (SIZE_BITS),
            .IW        (IW),
            .INDEX     (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_sel        (w_sel[g]),
            .i_size       (r_size),
            .i_found      (w_prev_found),
            .i_best_stamp (w_prev_stamp),
            .i_best_idx   (w_prev_idx),
            .i_best_bytes (w_prev_bytes),
            .o_found      (c_found[g]),
            .o_best_stamp (c_stamp[g]),
            .o_best_idx   (c_idx[g]),
            .o_best_bytes (c_bytes[g]),
            .o_valid      (c_valid[g]),
            .o_bytes      (c_own_bytes[g]),
            .o_stamp      (c_own_stamp[g])
        );
    end

    // Item payload is captured at acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= lsbe_pkg::t_op'(i_operation);
            r_idx      <= i_entry_index;
            r_size     <= SIZE_BITS'(i_entry_size);
            r_in_range <= w_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsbe_pkg::ST_IDLE;
            r_alloc     <= '0;
            r_total     <= '0;
            r_stamp_ctr <= '0;
            r_scan      <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A result taken while the next one is being loaded is replaced below.
            if (o_out_valid && i_out_ready && (r_state != lsbe_pkg::ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                lsbe_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_evict <= '0;
                        r_state <= lsbe_pkg::ST_APPLY;
                        if (w_in_range && (i_operation == lsbe_pkg::OP_ALLOC)) begin
                            if (w_alloc_next >= w_interval) begin
                                r_alloc <= '0;
                                r_state <= lsbe_pkg::ST_CHECK;
                            end else begin
                                r_alloc <= w_alloc_next;
                            end
                        end
                    end
                end
                lsbe_pkg::ST_CHECK: begin
                    r_scan  <= '0;
                    r_state <= w_over ? lsbe_pkg::ST_SCAN : lsbe_pkg::ST_APPLY;
                end
                lsbe_pkg::ST_SCAN: begin
                    // The last cell holds the oldest entry once the wave has crossed the row.
                    if (r_scan == SCW'(ENTRIES - 1)) begin
                        r_state <= lsbe_pkg::ST_EVICT;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                lsbe_pkg::ST_EVICT: begin
                    if (w_best_found) begin
                        r_total <= r_total - TW'(w_best_bytes);
                        r_evict <= r_evict + 1'b1;
                        r_state <= lsbe_pkg::ST_CHECK;
                    end else begin
                        r_state <= lsbe_pkg::ST_APPLY;
                    end
                end
                lsbe_pkg::ST_APPLY: begin
                    r_state <= lsbe_pkg::ST_OUT;
                    if (r_in_range) begin
                        case (r_op)
                            lsbe_pkg::OP_ALLOC: begin
                                r_total     <= r_total - w_rd_charge + TW'(r_size);
                                r_stamp_ctr <= n_stamp_ctr;
                            end
                            lsbe_pkg::OP_TOUCH: begin
                                if (w_rd_valid) begin
                                    r_stamp_ctr <= n_stamp_ctr;
                                end
                            end
                            lsbe_pkg::OP_QUERY: begin
                                r_stamp_ctr <= n_stamp_ctr;
                            end
                            lsbe_pkg::OP_RELEASE: begin
                                r_total <= r_total - w_rd_charge;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                lsbe_pkg::ST_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= lsbe_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= lsbe_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lsbe_pkg::ST_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_is_valid <= r_in_range && w_rd_valid;
            r_out_stamp    <= r_in_range ? w_rd_stamp : '0;
            r_out_total    <= lsbe_pkg::TOTAL_OUT_W'(r_total);
            r_out_evict    <= lsbe_pkg::EVICT_OUT_W'(r_evict);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_valid      = r_out_is_valid;
    assign o_total_in_use  = r_out_total;
    assign o_evicted_count = r_out_evict;
    assign o_use_stamp     = r_out_stamp;

    // An item in work blocks the input for at least the next cycle.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input accepted while an item was in work");

    // One pass cannot evict more entries than the table holds.
    a_evict_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_evict) <= ENTRIES)
        else $error("eviction count beyond table size");

    // An evicted entry's size is always covered by the running total.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lsbe_pkg::ST_EVICT) && w_best_found) |-> (r_total >= TW'(w_best_bytes)))
        else $error("eviction would drive the total below zero");

endmodule
